// File: hdl/sem_pkg.sv
// Shared types, constants and tap tables for the Sobel RGB edge magnitude core.
// Used by the ring memory, the per-channel magnitude unit and the top level.
package sem_pkg;

  localparam int SEM_MAX_WIDTH  = 1024;
  localparam int SEM_MAX_HEIGHT = 1024;
  localparam int CFG_DW         = 11;
  localparam int CFG_IW         = 2;
  localparam int PIX_W          = 24;

  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Smallest sum of squares whose rounded root exceeds 255.
  localparam logic [21:0] SQ_SAT = 22'd65281;
  localparam logic [7:0]  MAG_MAX = 8'd255;

  localparam logic [3:0] TAP_LAST  = 4'd8;
  localparam logic [3:0] ROOT_LAST = 4'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LAST,
    S_SQ,
    S_SUM,
    S_ROOT,
    S_RND,
    S_PUSH
  } sem_state_t;

  typedef struct packed {
    logic              clear;
    logic              acc_en;
    logic              tap_on;
    logic signed [2:0] coef_x;
    logic signed [2:0] coef_y;
    logic              sq_en;
    logic              sum_en;
    logic              root_en;
    logic [2:0]        root_bit;
    logic              rnd_en;
  } sem_ctl_t;

  // Taps are numbered row by row: tap = 3 * (dr + 1) + (dc + 1).
  function automatic logic signed [2:0] tap_cx(input logic [3:0] t);
    logic signed [2:0] c;
    unique case (t)
      4'd0, 4'd6: c = -3'sd1;
      4'd2, 4'd8: c = 3'sd1;
      4'd3:       c = -3'sd2;
      4'd5:       c = 3'sd2;
      default:    c = 3'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [2:0] tap_cy(input logic [3:0] t);
    logic signed [2:0] c;
    unique case (t)
      4'd0, 4'd2: c = -3'sd1;
      4'd1:       c = -3'sd2;
      4'd6, 4'd8: c = 3'sd1;
      4'd7:       c = 3'sd2;
      default:    c = 3'sd0;
    endcase
    return c;
  endfunction

  // -1, 0 or +1 as a two-bit code: bit 1 = up/left, bit 0 = down/right.
  function automatic logic [1:0] tap_row(input logic [3:0] t);
    logic [1:0] r;
    unique case (t)
      4'd0, 4'd1, 4'd2: r = 2'b10;
      4'd6, 4'd7, 4'd8: r = 2'b01;
      default:          r = 2'b00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_col(input logic [3:0] t);
    logic [1:0] c;
    unique case (t)
      4'd0, 4'd3, 4'd6: c = 2'b10;
      4'd2, 4'd5, 4'd8: c = 2'b01;
      default:          c = 2'b00;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/sem_ring_ram.sv
// Pixel ring memory indexed by raster position modulo its depth.
// One write port and one registered read port; uses sem_pkg.
module sem_ring_ram import sem_pkg::*; #(
  parameter int AW = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [2**AW];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/sem_magnitude.sv
// One color channel: accumulates Sobel Gx and Gy over nine taps, squares,
// saturates and takes a rounded square root bit by bit. Uses sem_pkg.
module sem_magnitude import sem_pkg::*; (
  input  logic       clk,
  input  sem_ctl_t   ctl,
  input  logic [7:0] pix,
  output logic [7:0] mag
);

  logic signed [10:0] gx_r, gy_r;
  logic [20:0]        gx2_r, gy2_r;
  logic [15:0]        s_r;
  logic               sat_r;
  logic [7:0]         m_r, mag_r;
  logic signed [10:0] vx, vy;
  logic [21:0]        sum;
  logic [7:0]         cand;
  logic [15:0]        csq;
  logic [16:0]        thr;

  function automatic logic signed [10:0] scale(input logic signed [2:0] c,
                                               input logic [7:0] v);
    logic signed [10:0] e;
    logic signed [10:0] r;
    e = $signed({3'b000, v});
    unique case (c)
      3'sd1:   r = e;
      3'sd2:   r = e <<< 1;
      -3'sd1:  r = -e;
      -3'sd2:  r = -(e <<< 1);
      default: r = 11'sd0;
    endcase
    return r;
  endfunction

  always_comb begin
    vx   = ctl.tap_on ? scale(ctl.coef_x, pix) : 11'sd0;
    vy   = ctl.tap_on ? scale(ctl.coef_y, pix) : 11'sd0;
    sum  = {1'b0, gx2_r} + {1'b0, gy2_r};
    cand = m_r | (8'd1 << ctl.root_bit);
    csq  = cand * cand;
    thr  = 17'(m_r) * 17'(m_r) + 17'(m_r) + 17'd1;
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      gx_r <= '0;
      gy_r <= '0;
    end else if (ctl.acc_en) begin
      gx_r <= gx_r + vx;
      gy_r <= gy_r + vy;
    end
    if (ctl.sq_en) begin
      gx2_r <= 21'(22'(gx_r) * 22'(gx_r));
      gy2_r <= 21'(22'(gy_r) * 22'(gy_r));
    end
    if (ctl.sum_en) begin
      sat_r <= (sum >= SQ_SAT);
      s_r   <= sum[15:0];
      m_r   <= '0;
    end else if (ctl.root_en && (csq <= s_r)) begin
      m_r <= cand;
    end
    if (ctl.rnd_en) begin
      // Halves round up: bump the floor root when s > m*m + m.
      mag_r <= sat_r ? MAG_MAX : m_r + 8'({16'd0, s_r} >= thr);
    end
  end

  assign mag = mag_r;

endmodule

// File: hdl/sobel_edge_magnitude_rgb_core.sv
// Top level of the Sobel RGB edge magnitude core: control sequencer, frame
// counters, ring memory and three channel units. Uses sem_pkg.
//
//   channel | direction | beat contents
//   in_     | slave     | tuser: kind; tdata: red, green, blue
//   out_    | master    | tlast: frame_end; tdata: red, green, blue
//   cfg_    | write     | index 0 image_width, index 1 image_height
//
// A beat that yields no result is taken in idle; one that yields a result runs
// through the accepting cycle, nine taps read through the single ring memory
// read port, the last tap, square and sum, eight root steps, a rounding step
// and the push into the output register; input waits until that push is done.
// Reset is synchronous; the ring memory needs no clearing since each entry is
// written in the current frame before it is read.
// A result waiting in the output register does not block input; the sequencer
// stalls only when a new result is ready while the old one is still held.
module sobel_edge_magnitude_rgb_core import sem_pkg::*; #(
  parameter int MAX_WIDTH  = SEM_MAX_WIDTH,
  parameter int MAX_HEIGHT = SEM_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [0:0]        in_tuser,   // [0] kind
  input  logic [23:0]       in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              out_tlast,  // frame_end
  output logic [23:0]       out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH) + 2;

  sem_state_t state_r, state_nxt;
  sem_ctl_t   ctl;

  logic [CFG_DW-1:0] cfg_w_r, cfg_h_r;
  logic              cfg_hold_r;
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic [CW-1:0]     total_r;
  logic [CW-1:0]     rcv_r, k_r;
  logic [CW-1:0]     rcv_new;
  logic [HW-1:0]     er_r;
  logic [WW-1:0]     ec_r;
  logic [3:0]        step_r;
  logic              rv_r, tok_r;
  logic [3:0]        tq_r;
  logic              accept, pix_wr, emit, tap_ok, push, out_ok, last_px;
  logic [AW-1:0]     raddr, woff;
  logic [1:0]        trow, tcol;
  logic [PIX_W-1:0]  rdata;
  logic [7:0]        mag_r8, mag_g8, mag_b8;
  logic              out_tvalid_r, out_tlast_r;
  logic [23:0]       out_tdata_r;

  always_comb begin
    if (cfg_w_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_h_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_h_r);
    end
  end

  assign in_tready = (state_r == S_IDLE) && !cfg_hold_r;
  assign accept    = in_tvalid && in_tready;
  assign pix_wr    = accept && !in_tuser[0] && (rcv_r < total_r);
  assign rcv_new   = pix_wr ? rcv_r + CW'(1) : rcv_r;
  assign emit      = (k_r < total_r) &&
                     (({1'b0, k_r} + (CW + 1)'(w_eff) + (CW + 1)'(2) <= {1'b0, rcv_new}) ||
                      (rcv_new == total_r));
  assign out_ok    = !out_tvalid_r || out_tready;
  assign push      = (state_r == S_PUSH) && out_ok;
  assign last_px   = (k_r + CW'(1) == total_r);

  // Neighbor address: raster position of the window center plus row and
  // column offsets, wrapping around the ring.
  always_comb begin
    trow = tap_row(step_r);
    tcol = tap_col(step_r);
    woff = AW'(w_eff);
    raddr = k_r[AW-1:0];
    if (trow[1]) raddr = raddr - woff;
    if (trow[0]) raddr = raddr + woff;
    if (tcol[1]) raddr = raddr - AW'(1);
    if (tcol[0]) raddr = raddr + AW'(1);
    tap_ok = 1'b1;
    if (trow[1] && (er_r == '0)) tap_ok = 1'b0;
    if (trow[0] && ({1'b0, er_r} + (HW + 1)'(1) >= {1'b0, h_eff})) tap_ok = 1'b0;
    if (tcol[1] && (ec_r == '0)) tap_ok = 1'b0;
    if (tcol[0] && ({1'b0, ec_r} + (WW + 1)'(1) >= {1'b0, w_eff})) tap_ok = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && emit) state_nxt = S_READ;
      S_READ: if (step_r == TAP_LAST) state_nxt = S_LAST;
      S_LAST: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_SUM;
      S_SUM:  state_nxt = S_ROOT;
      S_ROOT: if (step_r == ROOT_LAST) state_nxt = S_RND;
      S_RND:  state_nxt = S_PUSH;
      S_PUSH: if (out_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.clear    = accept && emit;
    ctl.acc_en   = rv_r;
    ctl.tap_on   = tok_r;
    ctl.coef_x   = tap_cx(tq_r);
    ctl.coef_y   = tap_cy(tq_r);
    ctl.sq_en    = (state_r == S_SQ);
    ctl.sum_en   = (state_r == S_SUM);
    ctl.root_en  = (state_r == S_ROOT);
    ctl.root_bit = 3'(ROOT_LAST - step_r);
    ctl.rnd_en   = (state_r == S_RND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_w_r      <= CFG_DW'(640);
      cfg_h_r      <= CFG_DW'(480);
      cfg_hold_r   <= 1'b1;
      rcv_r        <= '0;
      k_r          <= '0;
      er_r         <= '0;
      ec_r         <= '0;
      step_r       <= '0;
      rv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      // Totals follow the registers in the next cycle; hold input meanwhile.
      cfg_hold_r <= cfg_we;
      rv_r       <= (state_r == S_READ);
      if ((state_r == S_READ) || (state_r == S_ROOT)) begin
        step_r <= step_r + 4'd1;
      end else begin
        step_r <= '0;
      end
      if (pix_wr) begin
        rcv_r <= rcv_new;
      end
      if (push) begin
        out_tvalid_r <= 1'b1;
        if (last_px) begin
          rcv_r <= '0;
          k_r   <= '0;
          er_r  <= '0;
          ec_r  <= '0;
        end else begin
          k_r <= k_r + CW'(1);
          if ({1'b0, ec_r} + (WW + 1)'(1) == {1'b0, w_eff}) begin
            ec_r <= '0;
            er_r <= er_r + HW'(1);
          end else begin
            ec_r <= ec_r + WW'(1);
          end
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) cfg_w_r <= cfg_wdata;
        if (cfg_index == REG_IMAGE_HEIGHT) cfg_h_r <= cfg_wdata;
        if ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT)) begin
          rcv_r <= '0;
          k_r   <= '0;
          er_r  <= '0;
          ec_r  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r <= CW'(w_eff) * CW'(h_eff);
    tq_r    <= step_r;
    tok_r   <= tap_ok;
    if (push) begin
      out_tdata_r <= {mag_b8, mag_g8, mag_r8};
      out_tlast_r <= last_px;
    end
  end

  sem_ring_ram #(
    .AW(AW)
  ) u_ring (
    .clk  (clk),
    .we   (pix_wr),
    .waddr(rcv_r[AW-1:0]),
    .wdata(in_tdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  sem_magnitude u_mag_red (
    .clk(clk),
    .ctl(ctl),
    .pix(rdata[7:0]),
    .mag(mag_r8)
  );

  sem_magnitude u_mag_green (
    .clk(clk),
    .ctl(ctl),
    .pix(rdata[15:8]),
    .mag(mag_g8)
  );

  sem_magnitude u_mag_blue (
    .clk(clk),
    .ctl(ctl),
    .pix(rdata[23:16]),
    .mag(mag_b8)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: dv/tb.sv
// Self-checking testbench for sobel_edge_magnitude_rgb_core: a directed table and then
// random frames, with each result beat checked against a predictor inside the testbench.
// Depends on sem_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
  import sem_pkg::*;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;
  localparam logic [CFG_IW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SPARE_3 = 2'd3;
  localparam int TARGET_PIXELS = 1300;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;

  localparam int COEF_X [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  localparam int COEF_Y [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum logic {ROW_CFG, ROW_BEAT} row_op_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_chk_t;

  typedef struct packed {
    logic        last;
    logic [23:0] rgb;   // [7:0] red, [15:8] green, [23:16] blue
  } edge_beat_t;

  typedef struct {
    row_op_t           op;
    logic [CFG_IW-1:0] idx;
    logic [CFG_DW-1:0] val;
    logic              kind;
    logic [23:0]       px;
    row_chk_t          chk;
    edge_beat_t        want;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [0:0]        in_tuser;   // [0] kind
  logic [23:0]       in_tdata;   // [7:0] red, [15:8] green, [23:16] blue
  logic              out_tvalid;
  logic              out_tready;
  logic              out_tlast;  // frame_end
  logic [23:0]       out_tdata;  // [7:0] red, [15:8] green, [23:16] blue
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  sobel_edge_magnitude_rgb_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tlast(out_tlast),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: raw register values, frame position and the pixels of this frame.
  logic [CFG_DW-1:0] width_reg;
  logic [CFG_DW-1:0] height_reg;
  int                col_pos;
  int                row_pos;
  int                emitted;
  logic [23:0]       frame_px [int];

  edge_beat_t  pending_edges [$];
  idle_mode_t  idle_mode;
  int          mismatches;
  int          cycles;
  int          hold_ticket;
  int          hold_seen;
  int          hold_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int eff_dim(logic [CFG_DW-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // Rounded square root, halves up, saturating at 255.
  function automatic logic [7:0] rounded_root(int unsigned s);
    int unsigned m;
    if (s >= 65281) return 8'd255;
    m = 0;
    while ((m + 1) * (m + 1) <= s) m++;
    if (s >= m * m + m + 1) m++;
    return (m > 255) ? 8'd255 : m[7:0];
  endfunction

  task automatic predict_edge(input logic kind, input logic [23:0] px,
                              output bit got, output edge_beat_t res);
    int w, h, total, recv, i, j, ch, dr, dc, rr, cc, gx, gy, v;
    w = eff_dim(width_reg, SEM_MAX_WIDTH);
    h = eff_dim(height_reg, SEM_MAX_HEIGHT);
    total = w * h;
    recv = row_pos * w + col_pos;
    got = 0;
    res = '0;
    if (kind == KIND_PIXEL && recv < total) begin
      frame_px[recv] = px;
      recv++;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
    if (emitted >= total) return;
    if (!(emitted + w + 2 <= recv || recv == total)) return;
    i = emitted / w;
    j = emitted % w;
    for (ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          rr = i + dr;
          cc = j + dc;
          if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
            v = int'(frame_px[rr * w + cc][8 * ch +: 8]);
            gx += v * COEF_X[dr + 1][dc + 1];
            gy += v * COEF_Y[dr + 1][dc + 1];
          end
        end
      end
      res.rgb[8 * ch +: 8] = rounded_root(gx * gx + gy * gy);
    end
    res.last = (emitted + 1 == total);
    emitted++;
    if (emitted >= total) begin
      col_pos = 0;
      row_pos = 0;
      emitted = 0;
    end
    got = 1;
  endtask

  // Receiver: random stalls per idle mode, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLDOFF_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (idle_mode == IDLE_RECEIVER) begin
      out_tready <= ($urandom_range(99) >= 75);
    end else if (idle_mode == IDLE_BOTH) begin
      out_tready <= ($urandom_range(99) >= 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    edge_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: last %0b data %06h", out_tlast, out_tdata);
      end else begin
        want = pending_edges.pop_front();
        if (out_tdata[7:0] !== want.rgb[7:0] || out_tdata[15:8] !== want.rgb[15:8] ||
            out_tdata[23:16] !== want.rgb[23:16] || out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: want r %0d g %0d b %0d last %0b, ",
                      "got r %0d g %0d b %0d last %0b"},
                     want.rgb[7:0], want.rgb[15:8], want.rgb[23:16], want.last,
                     out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tlast);
        end
      end
    end
  end

  // Called just after a falling edge; returns just after a falling edge with tvalid still high.
  task automatic send_beat(input logic kind, input logic [23:0] px, input row_chk_t chk,
                           input edge_beat_t want);
    bit got;
    edge_beat_t res;
    while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 75) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 8)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_edge(kind, px, got, res);
    if (chk == CHK_TYPED) pending_edges.push_back(want);
    else if (chk == CHK_MODEL && got) pending_edges.push_back(res);
    @(negedge clk);
  endtask

  // Sender pauses until every expected beat has arrived and the core has settled.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
      if (idx == REG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
      col_pos = 0;
      row_pos = 0;
      emitted = 0;
    end
  endtask

  function automatic bit frame_idle();
    return col_pos == 0 && row_pos == 0 && emitted == 0;
  endfunction

  initial begin
    stim_row_t rows [$];
    int pixels_sent, p, f, frames, n, k, cut;
    logic [CFG_DW-1:0] wv, hv;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cycles = 0;
    mismatches = 0;
    hold_ticket = 0;
    hold_seen = 0;
    hold_left = 0;
    idle_mode = IDLE_NONE;
    width_reg = 11'd640;
    height_reg = 11'd480;
    col_pos = 0;
    row_pos = 0;
    emitted = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single pixel frame: all neighbors are padding, so the gradient is zero.
    rows.push_back('{ROW_CFG, REG_IMAGE_WIDTH, 11'd1, KIND_PIXEL, 24'h0, CHK_MODEL, '0});
    rows.push_back('{ROW_CFG, REG_IMAGE_HEIGHT, 11'd1, KIND_PIXEL, 24'h0, CHK_MODEL, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_DRAIN, 24'hFFFFFF, CHK_NONE, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'hFFFFFF, CHK_TYPED, '{1'b1, 24'h0}});
    // Two pixels in a row: the right one sees a full-scale red step on its left.
    rows.push_back('{ROW_CFG, REG_IMAGE_WIDTH, 11'd2, KIND_PIXEL, 24'h0, CHK_MODEL, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_DRAIN, 24'h0, CHK_NONE, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'h0000FF, CHK_NONE, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'h000000, CHK_TYPED, '{1'b0, 24'h0}});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_DRAIN, 24'h0, CHK_TYPED, '{1'b1, 24'h0000FF}});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_DRAIN, 24'h0, CHK_NONE, '0});
    // 3x3 frame with a drain in the middle, extra pixels after the end, spare indexes.
    rows.push_back('{ROW_CFG, REG_IMAGE_WIDTH, 11'd3, KIND_PIXEL, 24'h0, CHK_MODEL, '0});
    rows.push_back('{ROW_CFG, REG_IMAGE_HEIGHT, 11'd3, KIND_PIXEL, 24'h0, CHK_MODEL, '0});
    rows.push_back('{ROW_CFG, REG_SPARE_2, 11'h7FF, KIND_PIXEL, 24'h0, CHK_MODEL, '0});
    rows.push_back('{ROW_CFG, REG_SPARE_3, 11'h555, KIND_PIXEL, 24'h0, CHK_MODEL, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'hFFFFFF, CHK_MODEL, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'h000000, CHK_MODEL, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_DRAIN, 24'h123456, CHK_NONE, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'hFF00FF, CHK_MODEL, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'h00FF00, CHK_MODEL, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'hFFFFFF, CHK_MODEL, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'h000000, CHK_MODEL, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'hFFFFFF, CHK_MODEL, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'h80FF01, CHK_MODEL, '0});
    rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'h000000, CHK_MODEL, '0});
    for (k = 0; k < 6; k++)
      rows.push_back('{ROW_BEAT, '0, '0, KIND_PIXEL, 24'hA5A5A5, CHK_MODEL, '0});

    foreach (rows[r]) begin
      if (rows[r].op == ROW_CFG) write_reg(rows[r].idx, rows[r].val);
      else send_beat(rows[r].kind, rows[r].px, rows[r].chk, rows[r].want);
    end

    pixels_sent = 0;
    p = 0;
    while (pixels_sent < TARGET_PIXELS) begin
      idle_mode = idle_mode_t'(p % 4);
      if (p == 2) begin
        wv = 11'd6;     // enough results for the hold-off to fill the core
        hv = 11'd4;
      end else if (p == 5) begin
        wv = 11'd0;     // counts as one column
        hv = 11'h7FF;   // clamps to the tallest frame
      end else begin
        wv = ($urandom_range(9) == 0) ? 11'($urandom_range(40, 9)) : 11'($urandom_range(8, 1));
        hv = ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(6, 1));
      end
      if ($urandom_range(1)) begin
        write_reg(REG_IMAGE_WIDTH, wv);
        write_reg(REG_IMAGE_HEIGHT, hv);
      end else begin
        write_reg(REG_IMAGE_HEIGHT, hv);
        write_reg(REG_IMAGE_WIDTH, wv);
      end
      if ($urandom_range(7) == 0) write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                                            11'($urandom_range(2047)));
      frames = (p == 5) ? 1 : $urandom_range(3, 1);
      n = eff_dim(wv, SEM_MAX_WIDTH) * eff_dim(hv, SEM_MAX_HEIGHT);
      for (f = 0; f < frames; f++) begin
        // A long receiver hold-off fills the core while pixels keep coming.
        if (p == 2 && f == 0) hold_ticket++;
        cut = ($urandom_range(11) == 0 && n > 1 && p != 2) ? $urandom_range(n - 1, 1) : n;
        for (k = 0; k < cut; k++) begin
          if ($urandom_range(19) == 0) send_beat(KIND_DRAIN, 24'($urandom), CHK_MODEL, '0);
          send_beat(KIND_PIXEL, 24'($urandom), CHK_MODEL, '0);
          pixels_sent++;
        end
        // A cut frame is abandoned; the next register write restarts it.
        if (cut < n) break;
        while (!frame_idle())
          send_beat($urandom_range(9) == 0 ? KIND_PIXEL : KIND_DRAIN, 24'($urandom),
                    CHK_MODEL, '0);
        if ($urandom_range(3) == 0) send_beat(KIND_DRAIN, 24'($urandom), CHK_MODEL, '0);
      end
      p++;
    end

    wait_drained();
    if (mismatches == 0 && pending_edges.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
